>>> sv/rbft_pkg.sv
package rbft_pkg;

  // datapath vector width, enough for Q15.16 plus guard bits and cordic gain
  localparam int VW = 50;
  localparam int GUARD = 14;
  localparam int TABLE_LEN = 24;
  localparam logic signed [30:0] KINV = 31'sd652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  typedef enum logic {
    REQ_TO_GLOBAL = 1'b0,
    REQ_TO_LOCAL  = 1'b1
  } req_t;

  // items travelling alongside the yaw cordic
  typedef struct packed {
    req_t                    mode;
    logic signed [VW-1:0]    x0;
    logic signed [32:0]      dx;
    logic signed [32:0]      dy;
    logic [15:0]             bearing;
    logic signed [31:0]      px;
    logic signed [31:0]      py;
    logic signed [31:0]      pz;
  } yaw_pay_t;

  // items travelling alongside the main cordic
  typedef struct packed {
    req_t                    mode;
    logic [31:0]             yaw;
    logic signed [31:0]      px;
    logic signed [31:0]      py;
    logic signed [31:0]      pz;
    logic                    tzero;
  } main_pay_t;

  function automatic logic [31:0] atan_at(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051D;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2E;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/rbft_prep.sv
module rbft_prep (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_req_type,
  input  logic signed [31:0]        in_operand_a,
  input  logic signed [31:0]        in_operand_b,
  input  logic signed [31:0]        in_pos_x,
  input  logic signed [31:0]        in_pos_y,
  input  logic signed [31:0]        in_pos_z,
  input  logic signed [15:0]        in_quat_w,
  input  logic signed [15:0]        in_quat_x,
  input  logic signed [15:0]        in_quat_y,
  input  logic signed [15:0]        in_quat_z,
  output logic                      out_valid,
  output logic signed [rbft_pkg::VW-1:0] out_vx,
  output logic signed [rbft_pkg::VW-1:0] out_vy,
  output rbft_pkg::yaw_pay_t        out_pay
);
  import rbft_pkg::*;

  logic               v1_r, v2_r;
  req_t               mode1_r;
  logic signed [31:0] pww_r, pxx_r, pyy_r, pzz_r, pxy_r, pwz_r;
  logic signed [62:0] ak_r;
  logic signed [32:0] dx1_r, dy1_r;
  logic [15:0]        brg1_r;
  logic signed [31:0] px1_r, py1_r, pz1_r;
  logic signed [33:0] yx, yy;
  logic signed [VW-1:0] vx_r, vy_r;
  yaw_pay_t           pay_r, pay_nxt;

  // stage 1: products and differences
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    mode1_r <= req_t'(in_req_type);
    pww_r   <= in_quat_w * in_quat_w;
    pxx_r   <= in_quat_x * in_quat_x;
    pyy_r   <= in_quat_y * in_quat_y;
    pzz_r   <= in_quat_z * in_quat_z;
    pxy_r   <= in_quat_x * in_quat_y;
    pwz_r   <= in_quat_w * in_quat_z;
    ak_r    <= in_operand_a * KINV;
    dx1_r   <= 33'(in_operand_a) - 33'(in_pos_x);
    dy1_r   <= 33'(in_operand_b) - 33'(in_pos_y);
    brg1_r  <= in_operand_b[15:0];
    px1_r   <= in_pos_x;
    py1_r   <= in_pos_y;
    pz1_r   <= in_pos_z;
  end

  // stage 2: yaw vector and scaled range
  always_comb begin
    yx = 34'(pww_r) + 34'(pxx_r) - 34'(pyy_r) - 34'(pzz_r);
    yy = (34'(pxy_r) + 34'(pwz_r)) <<< 1;
    pay_nxt.mode    = mode1_r;
    pay_nxt.x0      = VW'(ak_r >>> 16);
    pay_nxt.dx      = dx1_r;
    pay_nxt.dy      = dy1_r;
    pay_nxt.bearing = brg1_r;
    pay_nxt.px      = px1_r;
    pay_nxt.py      = py1_r;
    pay_nxt.pz      = pz1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    vx_r  <= VW'(yx) <<< GUARD;
    vy_r  <= VW'(yy) <<< GUARD;
    pay_r <= pay_nxt;
  end

  assign out_valid = v2_r;
  assign out_vx    = vx_r;
  assign out_vy    = vy_r;
  assign out_pay   = pay_r;

endmodule

>>> sv/rbft_cordic.sv
module rbft_cordic #(
  parameter int STAGES = 16,
  parameter int PW     = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_vec,
  input  logic signed [rbft_pkg::VW-1:0] in_x,
  input  logic signed [rbft_pkg::VW-1:0] in_y,
  input  logic [31:0]                    in_z,
  input  logic [PW-1:0]                  in_pay,
  output logic                           out_valid,
  output logic signed [rbft_pkg::VW-1:0] out_x,
  output logic signed [rbft_pkg::VW-1:0] out_y,
  output logic [31:0]                    out_z,
  output logic [PW-1:0]                  out_pay
);
  import rbft_pkg::*;

  logic                 v_r    [0:STAGES];
  logic                 vec_r  [0:STAGES];
  logic                 zero_r [0:STAGES];
  logic signed [VW-1:0] x_r    [0:STAGES];
  logic signed [VW-1:0] y_r    [0:STAGES];
  logic [31:0]          z_r    [0:STAGES];
  logic [PW-1:0]        pay_r  [0:STAGES];

  logic signed [VW-1:0] fx, fy;
  logic [31:0]          fz;
  logic                 fzero;

  // fold into the convergence range by a half turn
  always_comb begin
    fx    = in_x;
    fy    = in_y;
    fz    = in_z;
    fzero = in_vec && (in_x == '0) && (in_y == '0);
    if (in_vec) begin
      if (in_x < 0) begin
        fx = -in_x;
        fy = -in_y;
        fz = in_z + HALF_TURN;
      end
    end else if (in_z[31] ^ in_z[30]) begin
      fx = -in_x;
      fz = in_z + HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    vec_r[0]  <= in_vec;
    zero_r[0] <= fzero;
    x_r[0]    <= fx;
    y_r[0]    <= fy;
    z_r[0]    <= fz;
    pay_r[0]  <= in_pay;
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_iter
    logic signed [VW-1:0] sx, sy;
    logic                 sg;
    assign sx = x_r[g] >>> g;
    assign sy = y_r[g] >>> g;
    assign sg = vec_r[g] ? y_r[g][VW-1] : ~z_r[g][31];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else begin
        v_r[g+1] <= v_r[g];
      end
      vec_r[g+1]  <= vec_r[g];
      zero_r[g+1] <= zero_r[g];
      x_r[g+1]    <= sg ? x_r[g] - sy : x_r[g] + sy;
      y_r[g+1]    <= sg ? y_r[g] + sx : y_r[g] - sx;
      z_r[g+1]    <= sg ? z_r[g] - atan_at(g) : z_r[g] + atan_at(g);
      pay_r[g+1]  <= pay_r[g];
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_x     = zero_r[STAGES] ? '0 : x_r[STAGES];
  assign out_y     = y_r[STAGES];
  assign out_z     = zero_r[STAGES] ? '0 : z_r[STAGES];
  assign out_pay   = pay_r[STAGES];

endmodule

>>> sv/rbft_post.sv
module rbft_post (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [rbft_pkg::VW-1:0] in_x,
  input  logic signed [rbft_pkg::VW-1:0] in_y,
  input  logic [31:0]                    in_z,
  input  rbft_pkg::main_pay_t            in_pay,
  output logic                           out_valid,
  output logic signed [31:0]             out_a,
  output logic signed [31:0]             out_b,
  output logic signed [31:0]             out_z,
  output logic                           out_saturated
);
  import rbft_pkg::*;

  localparam logic signed [VW-1:0] RND = VW'(1) <<< (GUARD - 1);
  localparam logic signed [66:0] RND30 = 67'sd1 <<< 29;

  logic               v1_r, v2_r, v3_r;
  req_t               mode1_r, mode2_r;
  logic signed [37:0] a1_r, b1_r, a2_r, b2_r;
  logic signed [31:0] z1_r, z2_r;
  logic signed [66:0] mk_r;
  logic signed [37:0] a1_nxt, b1_nxt;
  logic [31:0]        br;
  logic signed [37:0] rng;
  logic signed [31:0] oa_r, ob_r, oz_r;
  logic               sat_r;
  logic               sa, sb;
  logic signed [31:0] ca, cb;

  function automatic logic signed [31:0] clip(input logic signed [37:0] v,
                                              output logic hit);
    logic signed [31:0] r;
    hit = 1'b0;
    r   = v[31:0];
    if (v > 38'sd2147483647) begin
      hit = 1'b1;
      r   = 32'sh7FFF_FFFF;
    end else if (v < -38'sd2147483648) begin
      hit = 1'b1;
      r   = 32'sh8000_0000;
    end
    return r;
  endfunction

  // stage 1: drop guard bits, add platform position or form bearing
  always_comb begin
    br = in_z - in_pay.yaw + 32'h0000_8000;
    if (in_pay.mode == REQ_TO_GLOBAL) begin
      a1_nxt = 38'((in_x + RND) >>> GUARD) + 38'(in_pay.px);
      b1_nxt = 38'((in_y + RND) >>> GUARD) + 38'(in_pay.py);
    end else begin
      a1_nxt = 38'((in_x + RND) >>> GUARD);
      b1_nxt = in_pay.tzero ? '0 : 38'($signed(br[31:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    mode1_r <= in_pay.mode;
    a1_r    <= a1_nxt;
    b1_r    <= b1_nxt;
    z1_r    <= (in_pay.mode == REQ_TO_GLOBAL) ? in_pay.pz : '0;
    // stage 2: gain correction of the range
    mode2_r <= mode1_r;
    mk_r    <= 67'(a1_r[35:0]) * 67'(KINV);
    a2_r    <= a1_r;
    b2_r    <= b1_r;
    z2_r    <= z1_r;
    // stage 3: clip into the result registers
    oa_r    <= ca;
    ob_r    <= cb;
    oz_r    <= z2_r;
    sat_r   <= sa | sb;
  end

  always_comb begin
    rng = 38'((mk_r + RND30) >>> 30);
    if (mode2_r == REQ_TO_GLOBAL) begin
      ca = clip(a2_r, sa);
      cb = clip(b2_r, sb);
    end else begin
      ca = clip(rng, sa);
      cb = b2_r[31:0];
      sb = 1'b0;
    end
  end

  assign out_valid     = v3_r;
  assign out_a         = oa_r;
  assign out_b         = ob_r;
  assign out_z         = oz_r;
  assign out_saturated = sat_r;

endmodule

>>> sv/range_bearing_frame_transform.sv
// channel   ports                         transaction taken when
// -------   ---------------------------   -------------------------------
// request   start, busy, in_*             start high and busy low
// result    out_valid, out_*              out_valid high (one cycle)
//
// fully pipelined: one request per cycle, busy is never raised
// pipeline stages in order: two prep stages, yaw cordic and
// main cordic (fold stage plus one stage per iteration each), three post stages
// synchronous active-low reset clears only the valid bits
// results leave one cycle each and cannot be held back
module range_bearing_frame_transform #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  output logic signed [31:0] out_a,
  output logic signed [31:0] out_b,
  output logic signed [31:0] out_z,
  output logic               out_saturated
);
  import rbft_pkg::*;

  logic                 p_valid;
  logic signed [VW-1:0] p_vx, p_vy;
  yaw_pay_t             p_pay;

  logic                 y_valid;
  logic signed [VW-1:0] y_x, y_y;
  logic [31:0]          y_z;
  logic [$bits(yaw_pay_t)-1:0] y_pay_bits;
  yaw_pay_t             y_pay;

  logic                 m_vec;
  logic signed [VW-1:0] m_x, m_y;
  logic [31:0]          m_z;
  main_pay_t            m_pay;

  logic                 c_valid;
  logic signed [VW-1:0] c_x, c_y;
  logic [31:0]          c_z;
  logic [$bits(main_pay_t)-1:0] c_pay_bits;

  assign busy = 1'b0;

  rbft_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start),
    .in_req_type  (in_req_type),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_quat_w    (in_quat_w),
    .in_quat_x    (in_quat_x),
    .in_quat_y    (in_quat_y),
    .in_quat_z    (in_quat_z),
    .out_valid    (p_valid),
    .out_vx       (p_vx),
    .out_vy       (p_vy),
    .out_pay      (p_pay)
  );

  rbft_cordic #(.STAGES(CORDIC_STAGES), .PW($bits(yaw_pay_t))) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_vec    (1'b1),
    .in_x      (p_vx),
    .in_y      (p_vy),
    .in_z      (32'h0),
    .in_pay    (p_pay),
    .out_valid (y_valid),
    .out_x     (y_x),
    .out_y     (y_y),
    .out_z     (y_z),
    .out_pay   (y_pay_bits)
  );

  assign y_pay = yaw_pay_t'(y_pay_bits);

  // mode picks rotation of the range or vectoring of the offset
  always_comb begin
    m_pay.mode  = y_pay.mode;
    m_pay.yaw   = y_z;
    m_pay.px    = y_pay.px;
    m_pay.py    = y_pay.py;
    m_pay.pz    = y_pay.pz;
    m_pay.tzero = (y_pay.dx == '0) && (y_pay.dy == '0);
    if (y_pay.mode == REQ_TO_GLOBAL) begin
      m_vec = 1'b0;
      m_x   = y_pay.x0;
      m_y   = '0;
      m_z   = {y_pay.bearing, 16'h0000} + y_z;
    end else begin
      m_vec = 1'b1;
      m_x   = VW'(y_pay.dx) <<< GUARD;
      m_y   = VW'(y_pay.dy) <<< GUARD;
      m_z   = 32'h0;
    end
  end

  rbft_cordic #(.STAGES(CORDIC_STAGES), .PW($bits(main_pay_t))) u_main (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (y_valid & (y_x == y_x) & (y_y == y_y)),
    .in_vec    (m_vec),
    .in_x      (m_x),
    .in_y      (m_y),
    .in_z      (m_z),
    .in_pay    (m_pay),
    .out_valid (c_valid),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_z     (c_z),
    .out_pay   (c_pay_bits)
  );

  rbft_post u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (c_valid),
    .in_x          (c_x),
    .in_y          (c_y),
    .in_z          (c_z),
    .in_pay        (main_pay_t'(c_pay_bits)),
    .out_valid     (out_valid),
    .out_a         (out_a),
    .out_b         (out_b),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

endmodule

>>> tb/range_bearing_frame_transform_tb.sv
`timescale 1ns / 100ps

module range_bearing_frame_transform_tb;
  import rbft_pkg::*;

  localparam int STAGES = 16;
  localparam int N_RANDOM = 1150;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * STAGES + 20;

  localparam bit [31:0] ARCTAN [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct {
    req_t               mode;
    logic signed [31:0] a, b, px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
    bit                 drain;
  } target_t;

  typedef struct {
    logic signed [31:0] a, b, z;
    logic               sat;
  } point_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_req_type = 1'b0;
  logic signed [31:0] in_operand_a = '0, in_operand_b = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic               out_valid;
  logic signed [31:0] out_a, out_b, out_z;
  logic               out_saturated;

  target_t pending_targets[$];
  point_t  expected_points[$];
  target_t cur_target;
  int      gap = 0;
  bit      burst = 1'b0;
  int      n_sent = 0, n_checked = 0, n_errors = 0, n_sat = 0, idle_cycles = 0;
  bit      stim_done = 1'b0;

  range_bearing_frame_transform #(.CORDIC_STAGES(STAGES)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit [31:0] vector_angle(longint x, longint y, output longint mag);
    bit [31:0] ang;
    longint dx, dy;
    ang = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += ARCTAN[i];
      end else begin
        x -= dx; y += dy; ang -= ARCTAN[i];
      end
    end
    mag = x;
    return ang;
  endfunction

  function automatic void rotate_vec(longint x, bit [31:0] ang, output longint ox,
                                     output longint oy);
    longint y, dx, dy;
    y = 0;
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      x = -x;
      ang += 32'h8000_0000;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!ang[31]) begin
        x -= dx; y += dy; ang -= ARCTAN[i];
      end else begin
        x += dx; y -= dy; ang += ARCTAN[i];
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic longint clip32(longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic point_t transform_target(target_t t);
    point_t p;
    longint qw, qx, qy, qz, hx, hy, mag, gx, gy, dx, dy, m;
    bit [31:0] yaw, ang, br;
    bit s;
    qw = t.qw; qx = t.qx; qy = t.qy; qz = t.qz;
    s = 1'b0;
    hx = qw * qw + qx * qx - qy * qy - qz * qz;
    hy = 2 * (qx * qy + qw * qz);
    yaw = vector_angle(hx * 16384, hy * 16384, mag);
    if (t.mode == REQ_TO_GLOBAL) begin
      rotate_vec((longint'(t.a) * 64'sd652032874) >>> 16, {t.b[15:0], 16'h0} + yaw, gx, gy);
      p.a = 32'(clip32(((gx + 8192) >>> 14) + longint'(t.px), s));
      p.b = 32'(clip32(((gy + 8192) >>> 14) + longint'(t.py), s));
      p.z = t.pz;
    end else begin
      dx = longint'(t.a) - longint'(t.px);
      dy = longint'(t.b) - longint'(t.py);
      ang = vector_angle(dx * 16384, dy * 16384, mag);
      m = (mag + 8192) >>> 14;
      p.a = 32'(clip32((m * 64'sd652032874 + (64'sd1 << 29)) >>> 30, s));
      br = ang - yaw + 32'h8000;
      p.b = (dx == 0 && dy == 0) ? 32'sd0 : {{16{br[31]}}, br[31:16]};
      p.z = '0;
    end
    p.sat = s;
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: holds the current transaction until it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(transform_target(cur_target));
        n_sent++;
      end
      if (!start || !busy) begin
        if ($urandom_range(0, 63) == 0) burst = !burst;
        if (gap > 0) begin
          start <= 1'b0;
          gap <= gap - 1;
        end else if (pending_targets.size() > 0 &&
                     !(pending_targets[0].drain && expected_points.size() > 0)) begin
          cur_target = pending_targets.pop_front();
          start <= 1'b1;
          in_req_type <= cur_target.mode;
          in_operand_a <= cur_target.a;
          in_operand_b <= cur_target.b;
          in_pos_x <= cur_target.px;
          in_pos_y <= cur_target.py;
          in_pos_z <= cur_target.pz;
          in_quat_w <= cur_target.qw;
          in_quat_x <= cur_target.qx;
          in_quat_y <= cur_target.qy;
          in_quat_z <= cur_target.qz;
          gap <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result a=%0d b=%0d z=%0d sat=%0b",
                   out_a, out_b, out_z, out_saturated);
      end else begin
        e = expected_points.pop_front();
        n_checked++;
        if (e.sat) n_sat++;
        if (out_a !== e.a || out_b !== e.b || out_z !== e.z || out_saturated !== e.sat) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch #%0d: exp a=%0d b=%0d z=%0d sat=%0b got a=%0d b=%0d z=%0d sat=%0b",
                     n_checked, e.a, e.b, e.z, e.sat, out_a, out_b, out_z, out_saturated);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (!stim_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout with %0d results outstanding", expected_points.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return $signed($urandom_range(0, 2 * (1 << 20))) - (1 << 20);
      3: return $signed($urandom_range(0, 2 * (1 << 26))) - (1 << 26);
      4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'sh8000_0000 + $urandom_range(0, 255);
      default: return $signed($urandom_range(0, 512)) - 256;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic add_target(req_t mode, logic signed [31:0] a, b, px, py, pz,
                            logic signed [15:0] qw, qx, qy, qz, bit drain);
    target_t t;
    t.mode = mode; t.a = a; t.b = b; t.px = px; t.py = py; t.pz = pz;
    t.qw = qw; t.qx = qx; t.qy = qy; t.qz = qz; t.drain = drain;
    pending_targets.push_back(t);
  endtask

  initial begin
    target_t t;
    // directed: extremes, zero quaternion, target at platform, negative range, clipping
    add_target(REQ_TO_GLOBAL, 0, 0, 0, 0, 0, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_GLOBAL, 32'sh0001_0000, 0, 0, 0, 0, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_GLOBAL, 32'sh0001_0000, 32'h4000, 0, 0, 0, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_GLOBAL, 32'sh0001_0000, 32'h8000, 0, 0, 0, 16384, 0, 0, 16384, 0);
    add_target(REQ_TO_GLOBAL, 32'sh0001_0000, 32'hFFFF_FFFF, 5, -5, 7, 0, 0, 0, 0, 0);
    add_target(REQ_TO_GLOBAL, -32'sh0005_0000, 32'h2000, 0, 0, -1, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_GLOBAL, 32'sh7FFF_FFFF, 32'hC000, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh7FFF_FFFF, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_GLOBAL, 32'sh8000_0000, 32'h0000_7FFF, 32'sh8000_0000,
               32'sh7FFF_FFFF, 32'sh8000_0000, -16384, -16384, -16384, -16384, 0);
    add_target(REQ_TO_GLOBAL, 32'sh0003_0000, 32'h1234, 0, 0, 0, 100, 0, 0, 100, 0);
    add_target(REQ_TO_GLOBAL, 32'sh0003_0000, 32'h1234, 0, 0, 0, 16384, 0, 0, 16384, 0);
    add_target(REQ_TO_LOCAL, 32'sh0010_0000, 32'sh0020_0000, 32'sh0010_0000,
               32'sh0020_0000, 9, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_LOCAL, 32'sh0001_0000, 0, 0, 0, 0, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_LOCAL, 0, 32'sh0001_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    add_target(REQ_TO_LOCAL, -32'sh0001_0000, -32'sh0001_0000, 0, 0, 0, 0, 16384, 0, 0, 0);
    add_target(REQ_TO_LOCAL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
               32'sh8000_0000, 0, 16384, 0, 0, 0, 0);
    add_target(REQ_TO_LOCAL, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 16384, 0, 0);
    add_target(REQ_TO_LOCAL, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 16384, 16384, 16384,
               16384, 0);
    add_target(REQ_TO_LOCAL, 32'sh4000_0000, 32'sh4000_0000, 0, 0, 0, 5000, 0, 0, -5000, 1);
    add_target(REQ_TO_GLOBAL, 32'sh0100_0000, 32'hABCD, 1, 2, 3, 16384, 0, 0, -16384, 0);

    for (int i = 0; i < N_RANDOM; i++) begin
      t.mode = req_t'($urandom_range(0, 1));
      t.px = rand_coord(); t.py = rand_coord(); t.pz = rand_coord();
      t.qw = rand_quat(); t.qx = rand_quat(); t.qy = rand_quat(); t.qz = rand_quat();
      if (t.mode == REQ_TO_GLOBAL) begin
        t.a = ($urandom_range(0, 9) == 0) ? rand_coord() : $urandom_range(0, 32'h7FFF_FFFF);
        t.b = $urandom;
      end else if ($urandom_range(0, 3) == 0) begin
        // target near the platform, sometimes right on it
        t.a = t.px + (($urandom_range(0, 4) == 0) ? 0 : $signed($urandom_range(0, 64)) - 32);
        t.b = t.py + (($urandom_range(0, 4) == 0) ? 0 : $signed($urandom_range(0, 64)) - 32);
      end else begin
        t.a = rand_coord();
        t.b = rand_coord();
      end
      t.drain = (i % 300 == 150);
      pending_targets.push_back(t);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_targets.size() == 0 && !start && expected_points.size() == 0);
    stim_done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d transactions in both directions, %0d results checked, %0d clipped",
             n_sent, n_checked, n_sat);
    if (n_errors == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
